>>> design/crtc_pkg.sv
// Package for the cartridge real-time clock registers.
// Item type, function codes, register selects and modulo helpers.
// No dependencies.
package crtc_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    localparam logic [3:0] REG_SEC     = 4'd8;
    localparam logic [3:0] REG_MIN     = 4'd9;
    localparam logic [3:0] REG_HOUR    = 4'd10;
    localparam logic [3:0] REG_DAY_LO  = 4'd11;
    localparam logic [3:0] REG_DAY_HI  = 4'd12;

    localparam logic [5:0] SEC_LAST    = 6'd59;
    localparam logic [5:0] MIN_LAST    = 6'd59;
    localparam logic [4:0] HOUR_LAST   = 5'd23;

    typedef struct packed {
        t_func      func;
        logic [3:0] reg_select;
        logic [7:0] write_value;
    } t_item;

    // v mod 60: quotient estimate v*17/1024 is low by at most one
    function automatic logic [5:0] mod60(input logic [7:0] v);
        logic [12:0] prod;
        logic [2:0]  q;
        logic [8:0]  r;
        prod = 13'(v) * 13'd17;
        q    = prod[12:10];
        r    = 9'(v) - 9'(q) * 9'd60;
        if (r >= 9'd60) begin
            r = r - 9'd60;
        end
        return r[5:0];
    endfunction

    // v mod 24: quotient estimate v*43/1024 is high by at most one
    function automatic logic [4:0] mod24(input logic [7:0] v);
        logic [13:0]       prod;
        logic [3:0]        q;
        logic signed [9:0] r;
        prod = 14'(v) * 14'd43;
        q    = prod[13:10];
        r    = signed'(10'(v)) - signed'(10'(q) * 10'd24);
        if (r < 0) begin
            r = r + 10'sd24;
        end
        return r[4:0];
    endfunction

endpackage

>>> design/crtc_if.sv
// Valid/ready channel interfaces for the clock block.
// No dependencies.
interface crtc_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [3:0]          reg_select;
    logic [7:0]          write_value;

    modport source (output valid, output func, output reg_select, output write_value,
                    input ready);
    modport sink   (input valid, input func, input reg_select, input write_value,
                    output ready);
endinterface

interface crtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_value;

    modport source (output valid, output read_value, input ready);
    modport sink   (input valid, input read_value, output ready);
endinterface

>>> design/cartridge_rtc_registers.sv
// Top level of the cartridge real-time clock registers.
// Depends on crtc_pkg, crtc_if, crtc_time and crtc_out_stage.
//
//  channel  | dir | payload                          | words
//  ---------+-----+----------------------------------+-----------------------
//  i_in     | in  | func, reg_select, write_value    | tick, read or write
//  o_out    | out | read_value                       | one per read
//
// An accepted word sits in the input register, then updates the clock
// fields or loads the result register; a read passes both registers.
// One word per cycle is taken while the result register can drain.
// A read waits in the input register while a result is stalled; ticks and
// writes never wait. Synchronous reset clears time to day 0, 00:00:00.
module cartridge_rtc_registers (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crtc_in_if.sink    i_in,
    crtc_out_if.source o_out
);

    logic              r_in_valid;
    crtc_pkg::t_item   r_item;
    logic              out_free;
    logic              advance;
    logic              is_read;
    logic [7:0]        read_value;

    assign is_read    = (r_item.func == crtc_pkg::FUNC_READ);
    assign advance    = r_in_valid && (!is_read || out_free);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.func        <= crtc_pkg::t_func'(i_in.func);
            r_item.reg_select  <= i_in.reg_select;
            r_item.write_value <= i_in.write_value;
        end
    end

    crtc_time u_time (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_exec       (advance),
        .i_item       (r_item),
        .o_read_value (read_value)
    );

    crtc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && is_read),
        .i_data  (read_value),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_read) |=> o_out.valid)
        else $error("read result not loaded");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_item)))
        else $error("stalled word lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.read_value)))
        else $error("pending result overwritten");

endmodule

>>> design/crtc_time.sv
// Time-keeping registers: tick cascade, field writes and read mux.
// Depends on crtc_pkg.
module crtc_time (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_exec,
    input  crtc_pkg::t_item      i_item,
    output logic [7:0]           o_read_value
);

    logic [5:0] r_sec, n_sec;
    logic [5:0] r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [8:0] r_day, n_day;

    always_comb begin
        n_sec  = r_sec;
        n_min  = r_min;
        n_hour = r_hour;
        n_day  = r_day;
        if (i_exec) begin
            case (i_item.func)
                crtc_pkg::FUNC_TICK: begin
                    if (r_sec != crtc_pkg::SEC_LAST) begin
                        n_sec = r_sec + 6'd1;
                    end else begin
                        n_sec = '0;
                        if (r_min != crtc_pkg::MIN_LAST) begin
                            n_min = r_min + 6'd1;
                        end else begin
                            n_min = '0;
                            if (r_hour != crtc_pkg::HOUR_LAST) begin
                                n_hour = r_hour + 5'd1;
                            end else begin
                                n_hour = '0;
                                n_day  = r_day + 9'd1; // wraps at 512
                            end
                        end
                    end
                end
                crtc_pkg::FUNC_WRITE: begin
                    unique case (i_item.reg_select)
                        crtc_pkg::REG_SEC:    n_sec  = crtc_pkg::mod60(i_item.write_value);
                        crtc_pkg::REG_MIN:    n_min  = crtc_pkg::mod60(i_item.write_value);
                        crtc_pkg::REG_HOUR:   n_hour = crtc_pkg::mod24(i_item.write_value);
                        crtc_pkg::REG_DAY_LO: n_day  = {r_day[8], i_item.write_value};
                        crtc_pkg::REG_DAY_HI: n_day  = {i_item.write_value[0], r_day[7:0]};
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= '0;
            r_min  <= '0;
            r_hour <= '0;
            r_day  <= '0;
        end else begin
            r_sec  <= n_sec;
            r_min  <= n_min;
            r_hour <= n_hour;
            r_day  <= n_day;
        end
    end

    always_comb begin
        unique case (i_item.reg_select)
            crtc_pkg::REG_SEC:    o_read_value = {2'b00, r_sec};
            crtc_pkg::REG_MIN:    o_read_value = {2'b00, r_min};
            crtc_pkg::REG_HOUR:   o_read_value = {3'b000, r_hour};
            crtc_pkg::REG_DAY_LO: o_read_value = r_day[7:0];
            crtc_pkg::REG_DAY_HI: o_read_value = {7'd0, r_day[8]};
            default:              o_read_value = '0;
        endcase
    end

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sec <= crtc_pkg::SEC_LAST)
        else $error("seconds out of range");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hour <= crtc_pkg::HOUR_LAST)
        else $error("hours out of range");

    a_day_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_exec && i_item.func == crtc_pkg::FUNC_TICK && r_sec == crtc_pkg::SEC_LAST
         && r_min == crtc_pkg::MIN_LAST && r_hour == crtc_pkg::HOUR_LAST)
        |=> (r_day == $past(r_day) + 9'd1 && r_hour == 5'd0 && r_sec == 6'd0))
        else $error("day carry missed");

endmodule

>>> design/crtc_out_stage.sv
// Result register holding one read word until the sink takes it.
// Depends on crtc_if.
module crtc_out_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [7:0]    i_data,
    output logic          o_free,
    crtc_out_if.source    o_out
);

    logic       r_valid;
    logic [7:0] r_data;

    assign o_free           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.read_value = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule
